// ----- rtl/opd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_pkg: shared types and constants of the optical meter pulse detector
// Register map, reset values, configuration bundle and default widths.
// ----------------------------------------------------------------------------
package opd_pkg;

  localparam int SampleBitsDef = 8;
  localparam int CountBitsDef  = 16;

  localparam int OffsetBits  = 8;
  localparam int WidthBits   = 8;
  localparam int RefreshBits = 16;
  localparam int TickBits    = WidthBits + 1;
  localparam int CfgIdxBits  = 4;
  localparam int CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_THRESHOLD_OFFSET = 4'd0,
    CFG_MIN_WIDTH        = 4'd1,
    CFG_MAX_WIDTH        = 4'd2,
    CFG_REFRESH_SAMPLES  = 4'd3
  } cfg_idx_e;

  localparam logic [OffsetBits-1:0]  ThresholdOffsetRst = 8'd11;
  localparam logic [WidthBits-1:0]   MinWidthRst        = 8'd18;
  localparam logic [WidthBits-1:0]   MaxWidthRst        = 8'd22;
  localparam logic [RefreshBits-1:0] RefreshSamplesRst  = 16'd100;

  typedef struct packed {
    logic [OffsetBits-1:0]  threshold_offset;
    logic [WidthBits-1:0]   min_width;
    logic [WidthBits-1:0]   max_width;
    logic [RefreshBits-1:0] refresh_samples;
  } cfg_t;

endpackage

// ----- rtl/opd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_if: request channels of the pulse detector
// Sample channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface opd_sample_if #(
  parameter int SAMPLE_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pixel_sum;

  modport source (output valid, output pixel_sum, input ready);
  modport sink   (input valid, input pixel_sum, output ready);
endinterface

interface opd_result_if #(
  parameter int SAMPLE_BITS = 8,
  parameter int COUNT_BITS  = 16
);
  logic                   valid;
  logic                   ready;
  logic                   pulse_seen;
  logic [COUNT_BITS-1:0]  pulse_total;
  logic [SAMPLE_BITS-1:0] baseline_level;
  logic                   pulse_open;
  logic                   overlong;

  modport source (output valid, output pulse_seen, output pulse_total,
                  output baseline_level, output pulse_open, output overlong,
                  input ready);
  modport sink   (input valid, input pulse_seen, input pulse_total,
                  input baseline_level, input pulse_open, input overlong,
                  output ready);
endinterface

// ----- rtl/opd_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_cfg_regs: configuration register file
// Decodes the write port into the four settings; unknown indices are ignored.
// ----------------------------------------------------------------------------
module opd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [opd_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [opd_pkg::CfgDataBits-1:0] cfg_data_i,
  output opd_pkg::cfg_t                  cfg_o
);
  import opd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD_OFFSET: cfg_d.threshold_offset = cfg_data_i[OffsetBits-1:0];
        CFG_MIN_WIDTH:        cfg_d.min_width        = cfg_data_i[WidthBits-1:0];
        CFG_MAX_WIDTH:        cfg_d.max_width        = cfg_data_i[WidthBits-1:0];
        CFG_REFRESH_SAMPLES:  cfg_d.refresh_samples  = cfg_data_i[RefreshBits-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_offset <= ThresholdOffsetRst;
      cfg_q.min_width        <= MinWidthRst;
      cfg_q.max_width        <= MaxWidthRst;
      cfg_q.refresh_samples  <= RefreshSamplesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/opd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_step: per-sample detector datapath and state
// Baseline, pulse width, refresh and pulse counters; one sample per cycle while take_i is high.
// ----------------------------------------------------------------------------
module opd_step #(
  parameter int SAMPLE_BITS = opd_pkg::SampleBitsDef,
  parameter int COUNT_BITS  = opd_pkg::CountBitsDef,
  parameter int RES_BITS    = COUNT_BITS + SAMPLE_BITS + 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  opd_pkg::cfg_t          cfg_i,
  input  logic                   take_i,
  input  logic [SAMPLE_BITS-1:0] pixel_sum_i,
  output logic [RES_BITS-1:0]    res_o
);
  import opd_pkg::*;

  localparam int SumW = SAMPLE_BITS + 1;
  localparam int CmpW = (COUNT_BITS > RefreshBits) ? COUNT_BITS : RefreshBits;

  logic [SAMPLE_BITS-1:0] baseline_q, baseline_d;
  logic [TickBits-1:0]    ticks_q, ticks_d;
  logic [COUNT_BITS-1:0]  refresh_q, refresh_d;
  logic [COUNT_BITS-1:0]  pulses_q, pulses_d;

  logic [SAMPLE_BITS-1:0] base_min;
  logic [SumW-1:0]        thr;
  logic                   is_high;
  logic [TickBits-1:0]    ticks_inc;
  logic [COUNT_BITS-1:0]  refresh_inc;
  logic                   seen, dropped;

  always_comb begin
    base_min   = (baseline_q > pixel_sum_i) ? pixel_sum_i : baseline_q;
    thr        = SumW'(base_min) + SumW'(cfg_i.threshold_offset);
    is_high    = SumW'(pixel_sum_i) > thr;
    ticks_inc  = ticks_q + TickBits'(1);
    baseline_d = base_min;
    ticks_d    = '0;
    pulses_d   = pulses_q;
    seen       = 1'b0;
    dropped    = 1'b0;

    if (is_high) begin
      if (ticks_inc > TickBits'(cfg_i.max_width)) begin
        baseline_d = pixel_sum_i;
        dropped    = 1'b1;
      end else begin
        ticks_d = ticks_inc;
      end
    end else if (ticks_q != '0 && ticks_q >= TickBits'(cfg_i.min_width)
                 && ticks_q <= TickBits'(cfg_i.max_width)) begin
      pulses_d = pulses_q + COUNT_BITS'(1);
      seen     = 1'b1;
    end

    // saturating refresh counter
    refresh_inc = (&refresh_q) ? refresh_q : refresh_q + COUNT_BITS'(1);
    refresh_d   = refresh_inc;
    if (CmpW'(refresh_inc) > CmpW'(cfg_i.refresh_samples) && ticks_d == '0) begin
      refresh_d  = '0;
      baseline_d = pixel_sum_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
      ticks_q    <= '0;
      refresh_q  <= '0;
      pulses_q   <= '0;
    end else if (take_i) begin
      baseline_q <= baseline_d;
      ticks_q    <= ticks_d;
      refresh_q  <= refresh_d;
      pulses_q   <= pulses_d;
    end
  end

  assign res_o = {seen, pulses_d, baseline_d, (ticks_d != '0), dropped};

endmodule

// ----- rtl/opd_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opd_out_buf: output register with skid stage
// Holds up to two results so the input side keeps flowing on a stall.
// ----------------------------------------------------------------------------
module opd_out_buf #(
  parameter int WIDTH = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] data_o
);
  logic             main_vld_q, skid_vld_q;
  logic [WIDTH-1:0] main_q, skid_q;
  logic             pop;

  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;
  assign pop     = main_vld_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      main_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

// ----- rtl/optical_meter_pulse_detector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_meter_pulse_detector_core: meter LED pulse detector
// Counts valid-width light pulses over a running-minimum baseline.
// ----------------------------------------------------------------------------
// One brightness sample is taken per request and yields exactly one result
// request. Throughput is one sample per clock while the output buffer has
// room: all per-sample work (baseline minimum, threshold compare, width and
// refresh counters) sits in one short combinational pass from the detector
// state registers into the output register, or the skid stage on a stall.
// A two-entry output buffer (output register plus skid stage) lets the sample
// side keep flowing for one more request while a result is stalled; the
// sample side only backs off once both entries are occupied. Configuration
// writes take effect on the next cycle and should only be made while idle.
module optical_meter_pulse_detector_core #(
  parameter int SAMPLE_BITS = opd_pkg::SampleBitsDef,
  parameter int COUNT_BITS  = opd_pkg::CountBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [opd_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [opd_pkg::CfgDataBits-1:0] cfg_data_i,
  opd_sample_if.sink                      sample_i,
  opd_result_if.source                    result_o
);
  import opd_pkg::*;

  // result word: seen, total, baseline, open, overlong
  localparam int ResBits = COUNT_BITS + SAMPLE_BITS + 3;

  cfg_t               cfg;
  logic               take;
  logic               buf_ready;
  logic [ResBits-1:0] step_res;
  logic [ResBits-1:0] out_res;

  // register file
  opd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // a sample is taken whenever the buffer has room
  assign sample_i.ready = buf_ready;
  assign take           = sample_i.valid && buf_ready;

  opd_step #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .RES_BITS    (ResBits)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .take_i      (take),
    .pixel_sum_i (sample_i.pixel_sum),
    .res_o       (step_res)
  );

  opd_out_buf #(
    .WIDTH (ResBits)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .data_i      (step_res),
    .ready_o     (buf_ready),
    .valid_o     (result_o.valid),
    .pop_ready_i (result_o.ready),
    .data_o      (out_res)
  );

  // unpack result word onto the channel
  assign result_o.pulse_seen     = out_res[ResBits-1];
  assign result_o.pulse_total    = out_res[ResBits-2 -: COUNT_BITS];
  assign result_o.baseline_level = out_res[SAMPLE_BITS+1 -: SAMPLE_BITS];
  assign result_o.pulse_open     = out_res[1];
  assign result_o.overlong       = out_res[0];

  // an overlong drop closes the pulse and never counts it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !(result_o.overlong &&
                         (result_o.pulse_seen || result_o.pulse_open)))
    else $error("overlong result with pulse seen or open");

  // a counted pulse has ended, so no pulse may be open on that sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.pulse_seen) |-> !result_o.pulse_open)
    else $error("pulse counted while still open");

  // an accepted sample always leaves a result pending next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> result_o.valid)
    else $error("accepted sample produced no result");

  // back-pressure only when a result is already waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> result_o.valid)
    else $error("sample side stalled with empty output");

endmodule
